// File: hw/rtl/bilinear_texture_sampler_defines.svh
// assertion macros used by the texture sampler top module
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define BTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define BTS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assertion failed");
`else
`define BTS_ASSERT(lbl, clk, rst, prop)
`define BTS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: hw/rtl/bts_pkg.sv
// shared types and constants of the texture sampler
package bts_pkg;
   localparam int KIND_W     = 1;
   localparam int ADDR_W     = 12;
   localparam int DATA_W     = 32;
   localparam int COORD_W    = 24;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int CH_W       = 8;
   localparam int N_CH       = 4;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEX_WIDTH  = 2'd0,
      CSR_TEX_HEIGHT = 2'd1,
      CSR_FILTER     = 2'd2,
      CSR_WRAP       = 2'd3
   } csr_idx_type;

   typedef logic [DATA_W-1:0] texel_type;
endpackage

// File: hw/rtl/bts_ram.sv
// generic single write port ram with registered read
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/bts_wrap.sv
// pipelined coordinate wrap: remainder by texture side or clamp, gives c and c+1
module bts_wrap #(
   parameter int CIN_W = 16,
   parameter int LW    = 7,
   parameter int CW    = 6,
   parameter int TAG_W = 1,
   parameter int STEP  = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_vld,
   input  logic signed [CIN_W-1:0] in_coord,
   input  logic [LW-1:0]           lim,
   input  logic                    clamp,
   input  logic [TAG_W-1:0]        in_tag,
   output logic                    out_vld,
   output logic [CW-1:0]           out_c0,
   output logic [CW-1:0]           out_c1,
   output logic [TAG_W-1:0]        out_tag
);
   localparam int NST = (CIN_W + STEP - 1) / STEP;
   localparam int PW  = NST * STEP;
   localparam int RW  = LW + 1;

   function automatic logic [RW-1:0] rem_steps(logic [RW-1:0] r, logic [STEP-1:0] bits,
                                                logic [LW-1:0] d);
      logic [RW-1:0] t;
      logic [RW-1:0] acc;
      acc = r;
      for (int i = STEP - 1; i >= 0; i--) begin
         t = {acc[RW-2:0], bits[i]};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
         end
         acc = t;
      end
      return acc;
   endfunction

   function automatic logic [CW-1:0] clamp_c(logic signed [CIN_W:0] c, logic signed [CIN_W:0] l);
      logic [CW-1:0] res;
      if (c < 0) begin
         res = '0;
      end else if (c >= l) begin
         res = CW'(l - 1);
      end else begin
         res = CW'(c);
      end
      return res;
   endfunction

   logic signed [CIN_W:0] coord_ext;
   logic signed [CIN_W:0] coord_abs;
   logic [PW-1:0]         mag0;

   logic                    vld_ff   [NST];
   logic signed [CIN_W-1:0] coord_ff [NST];
   logic [PW-1:0]           mag_ff   [NST];
   logic [RW-1:0]           rem_ff   [NST];
   logic [TAG_W-1:0]        tag_ff   [NST];

   logic                    src_vld   [NST];
   logic signed [CIN_W-1:0] src_coord [NST];
   logic [PW-1:0]           src_mag   [NST];
   logic [RW-1:0]           src_rem   [NST];
   logic [TAG_W-1:0]        src_tag   [NST];
   logic [RW-1:0]           rem_in    [NST];

   always_comb begin
      coord_ext = in_coord;
      coord_abs = (coord_ext < 0) ? -coord_ext : coord_ext;
      mag0      = PW'(unsigned'(coord_abs));
   end

   for (genvar s = 0; s < NST; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_vld[s]   = in_vld;
         assign src_coord[s] = in_coord;
         assign src_mag[s]   = mag0;
         assign src_rem[s]   = '0;
         assign src_tag[s]   = in_tag;
      end else begin : g_next
         assign src_vld[s]   = vld_ff[s-1];
         assign src_coord[s] = coord_ff[s-1];
         assign src_mag[s]   = mag_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_tag[s]   = tag_ff[s-1];
      end

      assign rem_in[s] = rem_steps(src_rem[s], src_mag[s][PW-1-s*STEP -: STEP], lim);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld[s];
         end
         if (en) begin
            coord_ff[s] <= src_coord[s];
            mag_ff[s]   <= src_mag[s];
            rem_ff[s]   <= rem_in[s];
            tag_ff[s]   <= src_tag[s];
         end
      end
   end

   logic signed [CIN_W:0] last_c;
   logic signed [CIN_W:0] last_c1;
   logic signed [CIN_W:0] lim_s;
   logic [RW-1:0]         rep0;
   logic [RW-1:0]         rep1;
   logic [CW-1:0]         c0_in;
   logic [CW-1:0]         c1_in;

   always_comb begin
      last_c  = coord_ff[NST-1];
      last_c1 = last_c + 1;
      lim_s   = $signed({{(CIN_W + 1 - LW){1'b0}}, lim});
      if (last_c < 0 && rem_ff[NST-1] != '0) begin
         rep0 = {1'b0, lim} - rem_ff[NST-1];
      end else begin
         rep0 = rem_ff[NST-1];
      end
      rep1 = (rep0 + 1'b1 == {1'b0, lim}) ? '0 : rep0 + 1'b1;
      if (clamp) begin
         c0_in = clamp_c(last_c, lim_s);
         c1_in = clamp_c(last_c1, lim_s);
      end else begin
         c0_in = CW'(rep0);
         c1_in = CW'(rep1);
      end
   end

   logic             out_vld_ff;
   logic [CW-1:0]    c0_ff;
   logic [CW-1:0]    c1_ff;
   logic [TAG_W-1:0] out_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[NST-1];
      end
      if (en) begin
         c0_ff      <= c0_in;
         c1_ff      <= c1_in;
         out_tag_ff <= tag_ff[NST-1];
      end
   end

   assign out_vld = out_vld_ff;
   assign out_c0  = c0_ff;
   assign out_c1  = c1_ff;
   assign out_tag = out_tag_ff;
endmodule

// File: hw/rtl/bts_blend.sv
// two stage bilinear channel blend with round half up, nearest passthrough
module bts_blend (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic                      bilinear,
   input  bts_pkg::texel_type        t00,
   input  bts_pkg::texel_type        t10,
   input  bts_pkg::texel_type        t01,
   input  bts_pkg::texel_type        t11,
   input  logic [bts_pkg::FRAC_W-1:0] tx,
   input  logic [bts_pkg::FRAC_W-1:0] ty,
   output logic                      out_vld,
   output bts_pkg::texel_type        color
);
   import bts_pkg::*;

   localparam int TB_W = CH_W + FRAC_W;
   localparam int MX_W = TB_W + FRAC_W + 2;
   localparam logic [MX_W-1:0] ROUND = MX_W'(1) << (2 * FRAC_W - 1);
   localparam logic [CH_W+1:0] CH_MAX = (CH_W + 2)'((1 << CH_W) - 1);

   logic [TB_W-1:0] top_in [N_CH];
   logic [TB_W-1:0] bot_in [N_CH];

   always_comb begin
      logic signed [CH_W+1:0] sa, sb, sc, sd;
      logic signed [FRAC_W:0] txs;
      logic signed [TB_W+1:0] tf, bf;
      txs = $signed({1'b0, tx});
      for (int ch = 0; ch < N_CH; ch++) begin
         sa = $signed({2'b00, t00[ch*CH_W +: CH_W]});
         sb = $signed({2'b00, t10[ch*CH_W +: CH_W]});
         sc = $signed({2'b00, t01[ch*CH_W +: CH_W]});
         sd = $signed({2'b00, t11[ch*CH_W +: CH_W]});
         tf = ((TB_W + 2)'(sa) <<< FRAC_W) + (sb - sa) * txs;
         bf = ((TB_W + 2)'(sc) <<< FRAC_W) + (sd - sc) * txs;
         top_in[ch] = tf[TB_W-1:0];
         bot_in[ch] = bf[TB_W-1:0];
      end
   end

   logic              s1_vld_ff;
   logic              s1_bil_ff;
   texel_type         s1_near_ff;
   logic [FRAC_W-1:0] s1_ty_ff;
   logic [TB_W-1:0]   top_ff [N_CH];
   logic [TB_W-1:0]   bot_ff [N_CH];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
      end
      if (en) begin
         s1_bil_ff  <= bilinear;
         s1_near_ff <= t00;
         s1_ty_ff   <= ty;
         top_ff     <= top_in;
         bot_ff     <= bot_in;
      end
   end

   texel_type color_in;

   always_comb begin
      logic signed [TB_W:0]   ts, bs;
      logic signed [FRAC_W:0] tys;
      logic signed [MX_W-1:0] mix;
      logic [MX_W-1:0]        rnd;
      logic [CH_W+1:0]        o;
      tys      = $signed({1'b0, s1_ty_ff});
      color_in = '0;
      for (int ch = 0; ch < N_CH; ch++) begin
         ts  = $signed({1'b0, top_ff[ch]});
         bs  = $signed({1'b0, bot_ff[ch]});
         mix = (MX_W'(ts) <<< FRAC_W) + (bs - ts) * tys;
         rnd = unsigned'(mix) + ROUND;
         o   = rnd[MX_W-1 -: (CH_W + 2)];
         if (o > CH_MAX) begin
            o = CH_MAX;
         end
         color_in[ch*CH_W +: CH_W] = o[CH_W-1:0];
      end
      if (!s1_bil_ff) begin
         color_in = s1_near_ff;
      end
   end

   logic      out_vld_ff;
   texel_type color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         color_ff <= color_in;
      end
   end

   assign out_vld = out_vld_ff;
   assign color   = color_ff;
endmodule

// File: hw/rtl/bilinear_texture_sampler.sv
// bilinear texture sampler: an accepted sample passes the input and scale registers, the
// wrap pipeline, the tap address and ram read registers and the blend stages to the response
// throughput one transaction per cycle; the whole pipeline holds while a response stalls
// texel store is four ram copies, one per bilinear tap, all written by each in-range write
// synchronous reset clears valid bits and config (width 1, height 1, bilinear, repeat)
// texel contents are undefined after reset until written
`include "bilinear_texture_sampler_defines.svh"
module bilinear_texture_sampler #(
   parameter int MAX_TEXELS = 4096,
   parameter int MAX_SIDE   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bts_pkg::KIND_W-1:0]          req_kind,
   input  logic [bts_pkg::ADDR_W-1:0]          req_texel_addr,
   input  logic [bts_pkg::DATA_W-1:0]          req_texel_data,
   input  logic signed [bts_pkg::COORD_W-1:0]  req_u_coord,
   input  logic signed [bts_pkg::COORD_W-1:0]  req_v_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bts_pkg::DATA_W-1:0]          rsp_color,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bts_pkg::*;

   localparam int LW    = $clog2(MAX_SIDE + 1);
   localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int AW    = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
   localparam int SU_W  = COORD_W + LW + 1;
   localparam int FU_W  = SU_W + 1;
   localparam int CIN_W = FU_W - FRAC_W;
   localparam int IDX_W = CW + LW + 1;
   localparam int TAG_W = KIND_W + FRAC_W + ADDR_W + DATA_W;
   localparam logic signed [FU_W-1:0] HALF_Q = FU_W'(2 ** (FRAC_W - 1));

   function automatic logic [LW-1:0] eff_side(logic [CSR_DATA_W-1:0] r);
      logic [LW-1:0] res;
      if (r == '0) begin
         res = LW'(1);
      end else if (r > MAX_SIDE) begin
         res = LW'(MAX_SIDE);
      end else begin
         res = LW'(r);
      end
      return res;
   endfunction

   // configuration
   logic [LW-1:0] w_ff;
   logic [LW-1:0] h_ff;
   logic          filter_ff;
   logic          clamp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff      <= LW'(1);
         h_ff      <= LW'(1);
         filter_ff <= 1'b1;
         clamp_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_TEX_WIDTH:  w_ff      <= eff_side(csr_data);
            CSR_TEX_HEIGHT: h_ff      <= eff_side(csr_data);
            CSR_FILTER:     filter_ff <= csr_data[0];
            CSR_WRAP:       clamp_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // input register
   logic                      s1_vld_ff;
   logic [KIND_W-1:0]         s1_kind_ff;
   logic [ADDR_W-1:0]         s1_addr_ff;
   logic [DATA_W-1:0]         s1_data_ff;
   logic signed [COORD_W-1:0] s1_u_ff;
   logic signed [COORD_W-1:0] s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         s1_kind_ff <= req_kind;
         s1_addr_ff <= req_texel_addr;
         s1_data_ff <= req_texel_data;
         s1_u_ff    <= req_u_coord;
         s1_v_ff    <= req_v_coord;
      end
   end

   // scale by texture size
   logic signed [SU_W-1:0] su_in;
   logic signed [SU_W-1:0] sv_in;
   assign su_in = s1_u_ff * $signed({1'b0, w_ff});
   assign sv_in = s1_v_ff * $signed({1'b0, h_ff});

   logic                   s2_vld_ff;
   logic [KIND_W-1:0]      s2_kind_ff;
   logic [ADDR_W-1:0]      s2_addr_ff;
   logic [DATA_W-1:0]      s2_data_ff;
   logic signed [SU_W-1:0] s2_su_ff;
   logic signed [SU_W-1:0] s2_sv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_kind_ff <= s1_kind_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_data_ff <= s1_data_ff;
         s2_su_ff   <= su_in;
         s2_sv_ff   <= sv_in;
      end
   end

   // half texel offset in bilinear mode, integer and fraction split
   logic signed [FU_W-1:0] fu;
   logic signed [FU_W-1:0] fv;
   assign fu = FU_W'(s2_su_ff) - (filter_ff ? HALF_Q : '0);
   assign fv = FU_W'(s2_sv_ff) - (filter_ff ? HALF_Q : '0);

   logic              wx_vld;
   logic              wy_vld;
   logic [CW-1:0]     x0;
   logic [CW-1:0]     x1;
   logic [CW-1:0]     y0;
   logic [CW-1:0]     y1;
   logic [TAG_W-1:0]  x_tag;
   logic [FRAC_W-1:0] w_ty;

   bts_wrap #(
      .CIN_W (CIN_W),
      .LW    (LW),
      .CW    (CW),
      .TAG_W (TAG_W)
   ) u_wrap_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s2_vld_ff),
      .in_coord ($signed(fu[FU_W-1:FRAC_W])),
      .lim      (w_ff),
      .clamp    (clamp_ff),
      .in_tag   ({s2_kind_ff, fu[FRAC_W-1:0], s2_addr_ff, s2_data_ff}),
      .out_vld  (wx_vld),
      .out_c0   (x0),
      .out_c1   (x1),
      .out_tag  (x_tag)
   );

   bts_wrap #(
      .CIN_W (CIN_W),
      .LW    (LW),
      .CW    (CW),
      .TAG_W (FRAC_W)
   ) u_wrap_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s2_vld_ff),
      .in_coord ($signed(fv[FU_W-1:FRAC_W])),
      .lim      (h_ff),
      .clamp    (clamp_ff),
      .in_tag   (fv[FRAC_W-1:0]),
      .out_vld  (wy_vld),
      .out_c0   (y0),
      .out_c1   (y1),
      .out_tag  (w_ty)
   );

   logic [KIND_W-1:0] w_kind;
   logic [FRAC_W-1:0] w_tx;
   logic [ADDR_W-1:0] w_addr;
   logic [DATA_W-1:0] w_data;
   assign {w_kind, w_tx, w_addr, w_data} = x_tag;

   // tap addresses
   logic [IDX_W-1:0] idx_in [N_CH];
   always_comb begin
      idx_in[0] = IDX_W'(y0) * IDX_W'(w_ff) + IDX_W'(x0);
      idx_in[1] = IDX_W'(y0) * IDX_W'(w_ff) + IDX_W'(x1);
      idx_in[2] = IDX_W'(y1) * IDX_W'(w_ff) + IDX_W'(x0);
      idx_in[3] = IDX_W'(y1) * IDX_W'(w_ff) + IDX_W'(x1);
   end

   logic              a_vld_ff;
   logic [KIND_W-1:0] a_kind_ff;
   logic [FRAC_W-1:0] a_tx_ff;
   logic [FRAC_W-1:0] a_ty_ff;
   logic [AW-1:0]     a_raddr_ff [N_CH];
   logic [N_CH-1:0]   a_oob_ff;
   logic              a_wen_ff;
   logic [AW-1:0]     a_waddr_ff;
   logic [DATA_W-1:0] a_wdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         a_wen_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= wx_vld;
         a_wen_ff <= wx_vld && (w_kind == KIND_WRITE) && (w_addr < MAX_TEXELS);
      end
      if (en) begin
         a_kind_ff  <= w_kind;
         a_tx_ff    <= w_tx;
         a_ty_ff    <= w_ty;
         a_waddr_ff <= AW'(w_addr);
         a_wdata_ff <= w_data;
         for (int i = 0; i < N_CH; i++) begin
            a_raddr_ff[i] <= AW'(idx_in[i]);
            a_oob_ff[i]   <= idx_in[i] >= MAX_TEXELS;
         end
      end
   end

   // texel store copies
   texel_type rd_texel [N_CH];

   for (genvar i = 0; i < N_CH; i++) begin : g_bank
      bts_ram #(
         .WIDTH (DATA_W),
         .DEPTH (MAX_TEXELS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (a_wen_ff && en),
         .wr_addr (a_waddr_ff),
         .wr_data (a_wdata_ff),
         .rd_en   (en),
         .rd_addr (a_raddr_ff[i]),
         .rd_data (rd_texel[i])
      );
   end

   logic              b_vld_ff;
   logic [KIND_W-1:0] b_kind_ff;
   logic [FRAC_W-1:0] b_tx_ff;
   logic [FRAC_W-1:0] b_ty_ff;
   logic [N_CH-1:0]   b_oob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         b_kind_ff <= a_kind_ff;
         b_tx_ff   <= a_tx_ff;
         b_ty_ff   <= a_ty_ff;
         b_oob_ff  <= a_oob_ff;
      end
   end

   texel_type tap [N_CH];
   always_comb begin
      for (int i = 0; i < N_CH; i++) begin
         tap[i] = b_oob_ff[i] ? '0 : rd_texel[i];
      end
   end

   bts_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (b_vld_ff && (b_kind_ff == KIND_SAMPLE)),
      .bilinear (filter_ff),
      .t00      (tap[0]),
      .t10      (tap[1]),
      .t01      (tap[2]),
      .t11      (tap[3]),
      .tx       (b_tx_ff),
      .ty       (b_ty_ff),
      .out_vld  (rsp_valid),
      .color    (rsp_color)
   );

   `BTS_ASSERT(a_wrap_lockstep, clock, reset, wx_vld == wy_vld)
   `BTS_ASSERT(a_coord_range, clock, reset, !wx_vld || (x0 < w_ff && x1 < w_ff && y0 < h_ff && y1 < h_ff))
   `BTS_ASSERT(a_write_only, clock, reset, !a_wen_ff || (a_vld_ff && a_kind_ff == KIND_WRITE))
   `BTS_ASSERT_NEXT(a_sample_reaches_ram, clock, reset, a_vld_ff && a_kind_ff == KIND_SAMPLE && en, b_vld_ff && b_kind_ff == KIND_SAMPLE)
endmodule

// File: test/bilinear_texture_sampler_tb.sv
// self-checking testbench of the bilinear texture sampler: random stimulus, predictor, scoreboard
module bilinear_texture_sampler_tb;
   import bts_pkg::*;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [ADDR_W-1:0]         addr;
      logic [DATA_W-1:0]         data;
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
   } tex_txn_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [ADDR_W-1:0] req_texel_addr = '0;
   logic [DATA_W-1:0] req_texel_data = '0;
   logic signed [COORD_W-1:0] req_u_coord = '0;
   logic signed [COORD_W-1:0] req_v_coord = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_color;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   tex_txn_type pending_txns[$];
   tex_txn_type cur_txn;
   logic [DATA_W-1:0] expected_colors[$];
   logic [DATA_W-1:0] shadow_texels[4096];
   int unsigned cfg_width = 1, cfg_height = 1, cfg_filter = 1, cfg_wrap = 0;
   int n_samples = 0, n_writes = 0, n_errors = 0, n_phases = 0, idle_cnt = 0;
   int hold_cnt = 0;
   bit held = 1'b0;

   bilinear_texture_sampler u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint side_of(int unsigned r);
      if (r == 0) return 1;
      if (r > 64) return 64;
      return longint'(r);
   endfunction

   function automatic longint wrap_coord(longint c, longint lim);
      longint r;
      if (cfg_wrap == 0) begin
         r = c % lim;
         if (r < 0) r += lim;
         return r;
      end
      if (c < 0) return 0;
      if (c >= lim) return lim - 1;
      return c;
   endfunction

   function automatic logic [DATA_W-1:0] texel_at(longint x, longint y, longint w, longint h);
      longint idx;
      idx = wrap_coord(y, h) * w + wrap_coord(x, w);
      if (idx < 0 || idx >= 4096) return '0;
      return shadow_texels[idx[ADDR_W-1:0]];
   endfunction

   function automatic logic [DATA_W-1:0] filtered_color(longint u, longint v);
      longint w, h, su, sv, fu, fv, x0, y0, tx, ty, a, b, c, d, top, bot, mix, o;
      logic [DATA_W-1:0] c00, c10, c01, c11, res;
      w = side_of(cfg_width);
      h = side_of(cfg_height);
      su = u * w;
      sv = v * h;
      if (cfg_filter == 0) return texel_at(su >>> 16, sv >>> 16, w, h);
      fu = su - 32768;
      fv = sv - 32768;
      x0 = fu >>> 16;
      y0 = fv >>> 16;
      tx = fu - x0 * 65536;
      ty = fv - y0 * 65536;
      c00 = texel_at(x0, y0, w, h);
      c10 = texel_at(x0 + 1, y0, w, h);
      c01 = texel_at(x0, y0 + 1, w, h);
      c11 = texel_at(x0 + 1, y0 + 1, w, h);
      res = '0;
      for (int ch = 0; ch < N_CH; ch++) begin
         a = longint'(c00[ch*CH_W +: CH_W]);
         b = longint'(c10[ch*CH_W +: CH_W]);
         c = longint'(c01[ch*CH_W +: CH_W]);
         d = longint'(c11[ch*CH_W +: CH_W]);
         top = a * 65536 + (b - a) * tx;
         bot = c * 65536 + (d - c) * tx;
         mix = top * 65536 + (bot - top) * ty;
         o = (mix + 64'sh80000000) >>> 32;
         if (o > 255) o = 255;
         res[ch*CH_W +: CH_W] = o[CH_W-1:0];
      end
      return res;
   endfunction

   function automatic bit calm();
      return n_samples >= 600 && n_samples < 900;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            idle_cnt = 0;
            if (cur_txn.kind == KIND_SAMPLE) begin
               expected_colors.push_back(filtered_color(longint'(cur_txn.u),
                                                        longint'(cur_txn.v)));
               n_samples++;
            end else begin
               shadow_texels[cur_txn.addr] = cur_txn.data;
               n_writes++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_txns.size() > 0 && (calm() || $urandom_range(99) >= 25)) begin
               cur_txn = pending_txns.pop_front();
               req_kind <= cur_txn.kind;
               req_texel_addr <= cur_txn.addr;
               req_texel_data <= cur_txn.data;
               req_u_coord <= cur_txn.u;
               req_v_coord <= cur_txn.v;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      logic [DATA_W-1:0] exp_color;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            idle_cnt = 0;
            if (expected_colors.size() == 0) begin
               $display("%0t: unexpected transaction, color %h", $time, rsp_color);
               n_errors++;
            end else begin
               exp_color = expected_colors.pop_front();
               if (rsp_color !== exp_color) begin
                  $display("%0t: color mismatch, expected %h actual %h",
                           $time, exp_color, rsp_color);
                  n_errors++;
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else if (!held && n_samples >= 300) begin
            held = 1'b1;
            hold_cnt <= 150;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm() && $urandom_range(99) < 25;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         idle_cnt++;
         if (idle_cnt > 5000) begin
            $display("%0t: timeout", $time);
            $display("bilinear_texture_sampler verification failed");
            $finish;
         end
      end
   end

   task automatic add_txn(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                          logic [DATA_W-1:0] data, logic [COORD_W-1:0] u,
                          logic [COORD_W-1:0] v);
      tex_txn_type t;
      t.kind = kind;
      t.addr = addr;
      t.data = data;
      t.u = u;
      t.v = v;
      pending_txns.push_back(t);
   endtask

   task automatic drain();
      while (pending_txns.size() != 0 || req_valid || expected_colors.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      idle_cnt = 0;
      case (idx)
         CSR_TEX_WIDTH:  cfg_width = value & 32'h7F;
         CSR_TEX_HEIGHT: cfg_height = value & 32'h7F;
         CSR_FILTER:     cfg_filter = value & 32'h1;
         CSR_WRAP:       cfg_wrap = value & 32'h1;
         default: ;
      endcase
   endtask

   task automatic run_phase(int unsigned w, int unsigned h, int unsigned filt,
                            int unsigned wrp, int n_random);
      int area;
      logic [COORD_W-1:0] u, v;
      if (n_phases > 0) begin
         write_csr(CSR_TEX_WIDTH, w);
         write_csr(CSR_TEX_HEIGHT, h);
         write_csr(CSR_FILTER, filt);
         write_csr(CSR_WRAP, wrp);
      end
      n_phases++;
      area = int'(side_of(w) * side_of(h));
      for (int i = 0; i < area; i++)
         add_txn(KIND_WRITE, ADDR_W'(i), $urandom, COORD_W'($urandom), COORD_W'($urandom));
      for (int i = 0; i < n_random; i++) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) == 0)
               add_txn(KIND_WRITE, ADDR_W'($urandom_range(4095)), $urandom,
                       COORD_W'($urandom), COORD_W'($urandom));
            else
               add_txn(KIND_WRITE, ADDR_W'($urandom_range(area - 1)), $urandom,
                       COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            u = COORD_W'(($urandom_range(3) == 0) ? $urandom
                                                  : $urandom_range(524288) - 262144);
            v = COORD_W'(($urandom_range(3) == 0) ? $urandom
                                                  : $urandom_range(524288) - 262144);
            add_txn(KIND_SAMPLE, ADDR_W'($urandom), $urandom, u, v);
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // reset defaults: one texel, bilinear, repeat
      add_txn(KIND_WRITE, 12'hFFF, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000);
      add_txn(KIND_WRITE, 12'h000, 32'h0000_0000, 24'h800000, 24'h7FFFFF);
      add_txn(KIND_SAMPLE, 12'hFFF, 32'hFFFF_FFFF, 24'h000000, 24'h000000);
      add_txn(KIND_WRITE, 12'h000, 32'hFF80_7F01, 24'h000000, 24'h000000);
      add_txn(KIND_SAMPLE, 12'h000, 32'h0, 24'h7FFFFF, 24'h7FFFFF);
      add_txn(KIND_SAMPLE, 12'h000, 32'h0, 24'h800000, 24'h800000);
      add_txn(KIND_SAMPLE, 12'h000, 32'h0, 24'h800000, 24'h7FFFFF);
      add_txn(KIND_SAMPLE, 12'h000, 32'h0, 24'h008000, 24'hFF8000);
      add_txn(KIND_SAMPLE, 12'h000, 32'h0, 24'hFFFFFF, 24'h000001);
      drain();
      run_phase(1, 1, 1, 0, 30);
      run_phase(2, 2, 1, 0, 110);
      run_phase(4, 3, 0, 0, 170);
      run_phase(5, 7, 1, 1, 170);
      run_phase(0, 64, 0, 1, 130);
      run_phase(100, 1, 1, 1, 130);
      run_phase(64, 3, 1, 0, 150);
      run_phase(8, 8, 1, 0, 170);
      run_phase(3, 5, 0, 1, 150);
      run_phase(6, 2, 1, 1, 150);
      $display("covered %0d samples and %0d texel writes over %0d texture settings",
               n_samples, n_writes, n_phases);
      $display("filters, wrap modes, side extremes and a long response hold included");
      if (n_errors == 0 && expected_colors.size() == 0)
         $display("bilinear_texture_sampler verification clean");
      else
         $display("bilinear_texture_sampler verification failed");
      $finish;
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_ram.sv
hw/rtl/bts_wrap.sv
hw/rtl/bts_blend.sv
hw/rtl/bilinear_texture_sampler.sv
test/bilinear_texture_sampler_tb.sv
